FILE: rtl/lsb_first_bit_reader_core_assert.svh
// Assertion macros for the bit reader core module.
`ifndef LSB_FIRST_BIT_READER_CORE_ASSERT_SVH
`define LSB_FIRST_BIT_READER_CORE_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define LBR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bit reader assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bit reader assertion failed");

`else

`define LBR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define LBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/lbr_pkg.sv
package lbr_pkg;

	// Default depth of the byte store.
	localparam int LBR_STORE_BYTES = 4096;

	// Widest field a get or peek returns.
	localparam int LBR_MAX_FIELD_BITS = 25;

	// Four byte banks give a 32-bit window, enough for a full field at any bit offset.
	localparam int LBR_BANKS = 4;
	localparam int LBR_WINDOW_W = 8 * LBR_BANKS;

	localparam int LBR_POS_W = 16;
	localparam int LBR_LEN_W = 13;
	localparam int LBR_IDX_W = 14;
	localparam logic [LBR_POS_W-1:0] LBR_POS_MAX = 16'hFFFF;

	// Command codes.
	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_GET = 3'd1;
	localparam logic [2:0] CMD_PEEK = 3'd2;
	localparam logic [2:0] CMD_SKIP = 3'd3;
	localparam logic [2:0] CMD_SEEK = 3'd4;

	// Register index of stream_bytes (bit 2 of the byte address).
	localparam logic REG_STREAM_BYTES = 1'b0;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} lbr_state_t;

	// Request from the controller to the byte store.
	typedef struct packed {
		logic wr_en;
		logic [11:0] wr_addr;
		logic [7:0] wr_data;
		logic rd_en;
	} lbr_store_req_t;

endpackage

FILE: rtl/lsb_first_bit_reader_core.sv
// LSB-first bitstream reader. Bytes are loaded with write transactions and read back
// as a bit stream in which stream bit 8*b+k is bit k of byte b. A get returns the next
// 0 to 25 bits right aligned and advances the position, a peek returns them without
// advancing, a skip only advances, and a seek moves to a byte offset. Every transaction
// gives exactly one result, shown for a single cycle with done high; the receiver cannot
// stall, so it must take the result in that cycle. The byte store is four interleaved
// banks with a registered read: at acceptance they read the four bytes from the
// position upward; in the execute state, with busy high, the result is formed and the
// position updated. The result is shown in the next cycle, the first in which a new
// transaction is accepted. The user writes stream_bytes through the APB port while the
// block is idle, which the block does not enforce. Bytes at or past it read as zero.
module lsb_first_bit_reader_core import lbr_pkg::*; #(
	parameter int STORE_BYTES = LBR_STORE_BYTES
) (
	input logic clk,
	input logic arst_n,

	// Command transaction.
	input logic start,
	output logic busy,
	input logic [2:0] command,
	input logic [11:0] byte_address,
	input logic [7:0] byte_value,
	input logic [4:0] bit_count,
	input logic [11:0] seek_byte,

	// Result transaction.
	output logic done,
	output logic [LBR_MAX_FIELD_BITS-1:0] field_value,
	output logic out_of_range,

	// Configuration port.
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	`include "lsb_first_bit_reader_core_assert.svh"

	lbr_state_t state_q;
	lbr_state_t state_next;
	logic accept;

	logic [LBR_LEN_W-1:0] stream_bytes_q;
	logic [LBR_LEN_W-1:0] valid_bytes;
	logic [LBR_POS_W-1:0] stream_end;
	logic [LBR_POS_W-1:0] bit_position_q;

	// Command fields held for the execute cycle.
	logic [2:0] command_s1;
	logic [4:0] count_s1;
	logic [11:0] seek_s1;

	lbr_store_req_t store_req;
	logic [LBR_WINDOW_W-1:0] window;

	logic [LBR_POS_W:0] pos_sum;
	logic [LBR_POS_W-1:0] pos_adv;
	logic [LBR_WINDOW_W-1:0] shifted;
	logic [LBR_WINDOW_W-1:0] field_mask;
	logic [LBR_POS_W-1:0] pos_new;
	logic [LBR_MAX_FIELD_BITS-1:0] field_new;
	logic flag_new;

	logic done_q;
	logic [LBR_MAX_FIELD_BITS-1:0] field_value_q;
	logic out_of_range_q;

	// Configuration register. Bit 2 of the address selects the register; only
	// stream_bytes exists, the upper half of the map reads zero and ignores writes.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_STREAM_BYTES) ? 32'(stream_bytes_q) : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_bytes_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_STREAM_BYTES) begin
			stream_bytes_q <= pwdata[LBR_LEN_W-1:0];
		end
	end

	// A register value above the store depth counts as the full store.
	assign valid_bytes = (32'(stream_bytes_q) > 32'(STORE_BYTES)) ?
		LBR_LEN_W'(STORE_BYTES) : stream_bytes_q;
	assign stream_end = {valid_bytes, 3'b000};

	// The sequencer accepts in idle, then executes while the banks deliver data.
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		busy = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				busy = 1'b1;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1 <= command;
			// Counts above the widest field are clamped.
			count_s1 <= (bit_count > 5'(LBR_MAX_FIELD_BITS)) ? 5'(LBR_MAX_FIELD_BITS) : bit_count;
			seek_s1 <= seek_byte;
		end
	end

	// Writes go into the store at acceptance; every accepted command also reads the
	// window at the current position, which does not move before the execute cycle.
	always_comb begin
		store_req.wr_en = accept && (command == CMD_WRITE) &&
			(32'(byte_address) < 32'(STORE_BYTES));
		store_req.wr_addr = byte_address;
		store_req.wr_data = byte_value;
		store_req.rd_en = accept;
	end

	lbr_store #(
		.STORE_BYTES(STORE_BYTES)
	) u_store (
		.clk(clk),
		.req(store_req),
		.rd_pos(bit_position_q),
		.valid_bytes(valid_bytes),
		.window(window)
	);

	// Field extraction and position arithmetic for the execute cycle.
	assign pos_sum = {1'b0, bit_position_q} + (LBR_POS_W + 1)'(count_s1);
	assign pos_adv = pos_sum[LBR_POS_W] ? LBR_POS_MAX : pos_sum[LBR_POS_W-1:0];
	assign shifted = window >> bit_position_q[2:0];
	assign field_mask = (LBR_WINDOW_W'(1) << count_s1) - LBR_WINDOW_W'(1);

	always_comb begin
		pos_new = bit_position_q;
		field_new = '0;
		flag_new = 1'b0;
		case (command_s1)
			CMD_GET: begin
				flag_new = bit_position_q > stream_end;
				field_new = LBR_MAX_FIELD_BITS'(shifted & field_mask);
				pos_new = pos_adv;
			end
			CMD_PEEK: begin
				flag_new = bit_position_q > stream_end;
				field_new = LBR_MAX_FIELD_BITS'(shifted & field_mask);
			end
			CMD_SKIP: begin
				flag_new = pos_adv > stream_end;
				pos_new = pos_adv;
			end
			CMD_SEEK: begin
				// A seek at or past the stream end is rejected and leaves the position.
				if (LBR_LEN_W'(seek_s1) >= valid_bytes) begin
					flag_new = 1'b1;
				end else begin
					pos_new = {1'b0, seek_s1, 3'b000};
				end
			end
			default: begin
				pos_new = bit_position_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_position_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EXEC);
			if (state_q == ST_EXEC) begin
				bit_position_q <= pos_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			field_value_q <= field_new;
			out_of_range_q <= flag_new;
		end
	end

	assign done = done_q;
	assign field_value = field_value_q;
	assign out_of_range = out_of_range_q;

	`LBR_ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == ST_EXEC)
	`LBR_ASSERT_SAME(a_done_not_busy, clk, arst_n, done_q, !busy)
	`LBR_ASSERT_NEXT(a_peek_holds_pos, clk, arst_n, state_q == ST_EXEC && command_s1 == CMD_PEEK, $stable(bit_position_q))
	`LBR_ASSERT_NEXT(a_no_field, clk, arst_n, state_q == ST_EXEC && command_s1 != CMD_GET && command_s1 != CMD_PEEK, field_value_q == '0)
	`LBR_ASSERT_NEXT(a_write_in_range, clk, arst_n, state_q == ST_EXEC && command_s1 == CMD_WRITE, !out_of_range_q)

endmodule

FILE: rtl/lbr_ram.sv
module lbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/lbr_store.sv
module lbr_store import lbr_pkg::*; #(
	parameter int STORE_BYTES = LBR_STORE_BYTES
) (
	input logic clk,
	input lbr_store_req_t req,
	input logic [LBR_POS_W-1:0] rd_pos,
	input logic [LBR_LEN_W-1:0] valid_bytes,
	output logic [LBR_WINDOW_W-1:0] window
);

	localparam int BANK_DEPTH = (STORE_BYTES + LBR_BANKS - 1) / LBR_BANKS;
	localparam int ROW_W = $clog2(BANK_DEPTH);

	logic [LBR_LEN_W-1:0] base;
	logic [7:0] bank_data [LBR_BANKS];

	assign base = rd_pos[LBR_POS_W-1:3];

	// Bytes are interleaved over the banks by the two low address bits, so the
	// four bytes from base upward always sit in four different banks.
	for (genvar k = 0; k < LBR_BANKS; k++) begin : g_bank
		logic [1:0] rd_off;
		logic [LBR_IDX_W-1:0] rd_idx;
		logic bank_we;

		assign rd_off = 2'(k) - base[1:0];
		assign rd_idx = LBR_IDX_W'(base) + LBR_IDX_W'(rd_off);
		assign bank_we = req.wr_en && (req.wr_addr[1:0] == 2'(k));

		lbr_ram #(
			.WIDTH(8),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk(clk),
			.we(bank_we),
			.waddr(ROW_W'(req.wr_addr >> 2)),
			.wdata(req.wr_data),
			.re(req.rd_en),
			.raddr(ROW_W'(rd_idx >> 2)),
			.rdata(bank_data[k])
		);
	end

	// Bytes at or past the stream end read as zero.
	for (genvar j = 0; j < LBR_BANKS; j++) begin : g_window
		logic [1:0] sel;
		logic [LBR_IDX_W-1:0] idx;

		assign sel = base[1:0] + 2'(j);
		assign idx = LBR_IDX_W'(base) + LBR_IDX_W'(j);
		assign window[8*j +: 8] = (idx < LBR_IDX_W'(valid_bytes)) ? bank_data[sel] : 8'h00;
	end

endmodule

FILE: tb/tb_lsb_first_bit_reader_core.sv
module tb_lsb_first_bit_reader_core import lbr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Command codes that the block does not define. They must produce a zero result
	// and leave the position alone.
	localparam logic [2:0] CMD_RESERVED_5 = 3'd5;
	localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
	localparam logic [2:0] CMD_RESERVED_7 = 3'd7;

	// The only configuration register, stream_bytes, sits at byte address zero.
	localparam logic [2:0] ADDR_STREAM_BYTES = 3'd0;

	// Widest value that the 13-bit stream_bytes register holds.
	localparam int unsigned STREAM_BYTES_FULL = 8191;

	// The slowest correct run is under two thousand transactions, so this bound is many
	// times over what a healthy block needs.
	localparam int unsigned CYCLE_LIMIT = 400000;

	// Number of random transactions after the directed checks and the long climb.
	localparam int unsigned RANDOM_ITEMS = 200;

	// What one result transaction carries.
	typedef struct {
		logic [LBR_MAX_FIELD_BITS-1:0] field;
		logic flag;
	} bit_result_t;

	// The scoreboard keeps its own copy of the byte store, the bit position and the
	// stream length. Every accepted command transaction is run through it at once, and
	// the result it predicts waits in a queue until the block shows its result.
	class bit_reader_scoreboard;
		logic [7:0] stream_mem [LBR_STORE_BYTES];
		bit loaded [LBR_STORE_BYTES];
		logic [LBR_POS_W-1:0] read_pos;
		logic [LBR_LEN_W-1:0] stream_len_reg;
		bit_result_t expected_reads [$];
		int unsigned errors;

		function new();
			for (int i = 0; i < LBR_STORE_BYTES; i++) begin
				stream_mem[i] = 8'h00;
				loaded[i] = 1'b0;
			end
			read_pos = '0;
			stream_len_reg = '0;
			errors = 0;
		endfunction

		function int unsigned valid_bytes();
			return (stream_len_reg > LBR_STORE_BYTES) ? LBR_STORE_BYTES : stream_len_reg;
		endfunction

		function void set_stream_bytes(logic [31:0] data);
			stream_len_reg = data[LBR_LEN_W-1:0];
		endfunction

		// Index of the first byte inside the stream that a read at the current position
		// would fetch without it ever having been loaded, or -1 when there is none.
		function int first_missing_byte();
			int unsigned base;
			int unsigned len;
			base = read_pos >> 3;
			len = valid_bytes();
			for (int k = 0; k < LBR_BANKS; k++)
				if (base + k < len && !loaded[base + k])
					return base + k;
			return -1;
		endfunction

		// Bits pos .. pos+n-1 of the stream, least significant first. Bytes at or past
		// the stream end count as zero.
		function logic [LBR_MAX_FIELD_BITS-1:0] extract(logic [LBR_POS_W-1:0] pos,
				int unsigned n);
			logic [63:0] window;
			int unsigned base;
			int unsigned len;
			window = '0;
			base = pos >> 3;
			len = valid_bytes();
			for (int k = 0; k < 8; k++)
				if (base + k < len)
					window |= 64'(stream_mem[base + k]) << (8 * k);
			window = window >> pos[2:0];
			if (n == 0)
				return '0;
			return LBR_MAX_FIELD_BITS'(window & ((64'd1 << n) - 64'd1));
		endfunction

		function logic [LBR_POS_W-1:0] advance(logic [LBR_POS_W-1:0] pos, int unsigned n);
			int unsigned sum;
			sum = pos + n;
			return (sum > LBR_POS_MAX) ? LBR_POS_MAX : sum[LBR_POS_W-1:0];
		endfunction

		function void note_command(logic [2:0] cmd, logic [11:0] addr, logic [7:0] value,
				logic [4:0] count, logic [11:0] seek);
			bit_result_t r;
			int unsigned n;
			int unsigned end_bits;
			r.field = '0;
			r.flag = 1'b0;
			n = (count > LBR_MAX_FIELD_BITS) ? LBR_MAX_FIELD_BITS : count;
			end_bits = valid_bytes() * 8;
			case (cmd)
				CMD_WRITE: begin
					stream_mem[addr] = value;
					loaded[addr] = 1'b1;
				end
				CMD_GET: begin
					r.flag = (read_pos > end_bits);
					r.field = extract(read_pos, n);
					read_pos = advance(read_pos, n);
				end
				CMD_PEEK: begin
					r.flag = (read_pos > end_bits);
					r.field = extract(read_pos, n);
				end
				CMD_SKIP: begin
					read_pos = advance(read_pos, n);
					r.flag = (read_pos > end_bits);
				end
				CMD_SEEK: begin
					if (seek >= valid_bytes())
						r.flag = 1'b1;
					else
						read_pos = LBR_POS_W'(seek) << 3;
				end
				default: ;
			endcase
			expected_reads.push_back(r);
		endfunction

		function void check_result(logic [LBR_MAX_FIELD_BITS-1:0] field, logic flag);
			bit_result_t r;
			if (expected_reads.size() == 0) begin
				$display("%0t: result with none expected, field_value %h out_of_range %b",
					$time, field, flag);
				errors++;
				return;
			end
			r = expected_reads.pop_front();
			if (field !== r.field) begin
				$display("%0t: field_value expected %h actual %h", $time, r.field, field);
				errors++;
			end
			if (flag !== r.flag) begin
				$display("%0t: out_of_range expected %b actual %b", $time, r.flag, flag);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] command;
	logic [11:0] byte_address;
	logic [7:0] byte_value;
	logic [4:0] bit_count;
	logic [11:0] seek_byte;
	logic done;
	logic [LBR_MAX_FIELD_BITS-1:0] field_value;
	logic out_of_range;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	bit_reader_scoreboard sb;
	int unsigned cycles;
	int unsigned items_sent;
	int unsigned burst_left;

	lsb_first_bit_reader_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.byte_address(byte_address),
		.byte_value(byte_value),
		.bit_count(bit_count),
		.seek_byte(seek_byte),
		.done(done),
		.field_value(field_value),
		.out_of_range(out_of_range),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The run is cut off if it takes far longer than any correct block would.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_lsb_first_bit_reader_core: errors");
			$finish;
		end
	end

	// Results cannot be held off, so each cycle with done high is one result
	// transaction. The values read here are the ones from before the edge.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(field_value, out_of_range);
	end

	// Presents one command transaction and holds it until the block takes it, that is
	// until an edge at which start is high and busy is low. The prediction is made at
	// that edge. start is left high so that a following transaction can go back to back.
	task automatic send_command(input logic [2:0] cmd, input logic [11:0] addr,
			input logic [7:0] value, input logic [4:0] count, input logic [11:0] seek);
		start <= 1'b1;
		command <= cmd;
		byte_address <= addr;
		byte_value <= value;
		bit_count <= count;
		seek_byte <= seek;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(cmd, addr, value, count, seek);
		items_sent++;
	endtask

	// A get or peek must never fetch a store entry inside the stream that was never
	// loaded. When the read at the current position would, that byte is loaded in its
	// place with a random value, so reads further on find real data.
	task automatic send_read(input logic [2:0] cmd, input logic [4:0] count);
		int miss;
		miss = sb.first_missing_byte();
		if (miss >= 0)
			send_command(CMD_WRITE, miss[11:0], 8'($urandom), 5'($urandom), 12'($urandom));
		else
			send_command(cmd, 12'($urandom), 8'($urandom), count, 12'($urandom));
	endtask

	// The sender works in bursts of random length. Between bursts start drops for a
	// random number of cycles, so gaps fall both while the block is busy and while it
	// is showing a result. A gap is never empty: dropping start and raising it again in
	// the same step would be two assignments to it in one step.
	task automatic pace();
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap)
				@(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
				: $urandom_range(1, 20);
		end
		burst_left--;
	endtask

	// Holds the sender off until every predicted result has come back, then lets a
	// few more cycles pass so the block is surely idle before the register changes.
	task automatic wait_drained();
		start <= 1'b0;
		while (sb.expected_reads.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		burst_left = 0;
	endtask

	// Setup cycle, then access cycle; the register takes the data at the edge that ends
	// the access cycle, since pready is always high.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_stream_bytes(data);
	endtask

	// One random transaction. All fields start random, so the ones that a command
	// ignores still toggle; then the fields that matter are shaped so that most seeks
	// land inside the stream and many writes change the bytes about to be read.
	task automatic random_item();
		int unsigned pick;
		int unsigned len;
		logic [11:0] addr;
		logic [11:0] seek;
		logic [4:0] count;
		len = sb.valid_bytes();
		pick = $urandom_range(0, 99);
		count = 5'($urandom);
		if (pick < 26) begin
			if ($urandom_range(0, 1) == 0)
				addr = 12'((sb.read_pos >> 3) + $urandom_range(0, LBR_BANKS));
			else if (len > 0 && $urandom_range(0, 1) == 0)
				addr = 12'($urandom_range(0, len - 1));
			else
				addr = 12'($urandom);
			send_command(CMD_WRITE, addr, 8'($urandom), 5'($urandom), 12'($urandom));
		end else if (pick < 52) begin
			send_read(CMD_GET, count);
		end else if (pick < 67) begin
			send_read(CMD_PEEK, count);
		end else if (pick < 81) begin
			send_command(CMD_SKIP, 12'($urandom), 8'($urandom), count, 12'($urandom));
		end else if (pick < 97) begin
			if ($urandom_range(0, 3) != 0)
				seek = 12'($urandom_range(0, (len > 4095) ? 4095 : len));
			else
				seek = 12'($urandom);
			send_command(CMD_SEEK, 12'($urandom), 8'($urandom), 5'($urandom), seek);
		end else begin
			send_command(3'($urandom_range(CMD_RESERVED_5, CMD_RESERVED_7)), 12'($urandom),
				8'($urandom), 5'($urandom), 12'($urandom));
		end
	endtask

	initial begin
		int unsigned random_goal;
		int unsigned phase_items;
		int unsigned len;
		logic [31:0] reg_data;

		sb = new();
		cycles = 0;
		items_sent = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= CMD_WRITE;
		byte_address <= '0;
		byte_value <= '0;
		bit_count <= '0;
		seek_byte <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stream. Nothing can be read, every position past zero is past the end,
		// and every seek is refused. The reserved command codes go here too.
		apb_write(ADDR_STREAM_BYTES, 32'd0);
		pace(); send_command(CMD_GET, 12'hFFF, 8'hFF, 5'd25, 12'hFFF);
		pace(); send_command(CMD_SKIP, 12'h000, 8'h00, 5'd1, 12'h000);
		pace(); send_command(CMD_PEEK, 12'h000, 8'h00, 5'd31, 12'h000);
		pace(); send_command(CMD_SEEK, 12'h000, 8'h00, 5'd0, 12'h000);
		pace(); send_command(CMD_RESERVED_5, 12'hFFF, 8'hFF, 5'd31, 12'hFFF);
		pace(); send_command(CMD_RESERVED_6, 12'h000, 8'h00, 5'd0, 12'h000);
		pace(); send_command(CMD_RESERVED_7, 12'hA5A, 8'h5A, 5'd17, 12'h5A5);

		// A five-byte stream with extreme byte values. The reads cover an empty field,
		// a count above the widest field (clamped), a read that runs past the last
		// byte, a position exactly at the end (still in range) and one bit beyond it,
		// a skip that lands past the end, and a seek to the first byte out of range.
		wait_drained();
		apb_write(ADDR_STREAM_BYTES, 32'd5);
		pace(); send_command(CMD_WRITE, 12'd0, 8'hFF, 5'd0, 12'd0);
		pace(); send_command(CMD_WRITE, 12'd1, 8'h00, 5'd0, 12'd0);
		pace(); send_command(CMD_WRITE, 12'd2, 8'hA5, 5'd0, 12'd0);
		pace(); send_command(CMD_WRITE, 12'd3, 8'h5A, 5'd0, 12'd0);
		pace(); send_command(CMD_WRITE, 12'd4, 8'h81, 5'd0, 12'd0);
		pace(); send_command(CMD_SEEK, 12'd0, 8'd0, 5'd0, 12'd0);
		pace(); send_command(CMD_GET, 12'd0, 8'd0, 5'd0, 12'd0);
		pace(); send_command(CMD_GET, 12'd0, 8'd0, 5'd3, 12'd0);
		pace(); send_command(CMD_PEEK, 12'd0, 8'd0, 5'd31, 12'd0);
		pace(); send_command(CMD_GET, 12'd0, 8'd0, 5'd25, 12'd0);
		pace(); send_command(CMD_SKIP, 12'd0, 8'd0, 5'd31, 12'd0);
		pace(); send_command(CMD_SEEK, 12'd0, 8'd0, 5'd0, 12'd4);
		pace(); send_command(CMD_GET, 12'd0, 8'd0, 5'd8, 12'd0);
		pace(); send_command(CMD_PEEK, 12'd0, 8'd0, 5'd9, 12'd0);
		pace(); send_command(CMD_GET, 12'd0, 8'd0, 5'd1, 12'd0);
		pace(); send_command(CMD_PEEK, 12'd0, 8'd0, 5'd1, 12'd0);
		pace(); send_command(CMD_SEEK, 12'd0, 8'd0, 5'd0, 12'd5);

		// The largest register value counts as a full store. From the last byte of the
		// store, skips and gets climb until the position saturates, and a few more
		// transactions then check that it stays there.
		wait_drained();
		apb_write(ADDR_STREAM_BYTES, STREAM_BYTES_FULL);
		pace(); send_command(CMD_SEEK, 12'($urandom), 8'($urandom), 5'($urandom), 12'd4095);
		while (sb.read_pos != LBR_POS_MAX) begin
			pace();
			if ($urandom_range(0, 7) == 0)
				send_read(CMD_GET, 5'($urandom_range(25, 31)));
			else
				send_command(CMD_SKIP, 12'($urandom), 8'($urandom),
					5'($urandom_range(25, 31)), 12'($urandom));
		end
		pace(); send_read(CMD_GET, 5'd31);
		pace(); send_read(CMD_PEEK, 5'd7);
		pace(); send_command(CMD_SKIP, 12'($urandom), 8'($urandom), 5'd3, 12'($urandom));
		pace(); send_read(CMD_GET, 5'd0);

		// Random phases, each with its own stream length: mostly short streams, which
		// fill quickly and so give many reads of real data, and now and then an empty
		// stream, a full one, a register value above the store size, or a long one.
		// The upper data bits of the register write are noise that must be ignored.
		random_goal = items_sent + RANDOM_ITEMS;
		while (items_sent < random_goal) begin
			wait_drained();
			case ($urandom_range(0, 9))
				0: len = 0;
				1: len = LBR_STORE_BYTES;
				2: len = $urandom_range(LBR_STORE_BYTES + 1, STREAM_BYTES_FULL);
				3: len = 1;
				4, 5: len = $urandom_range(2, 16);
				6, 7: len = $urandom_range(17, 64);
				8: len = $urandom_range(65, LBR_STORE_BYTES - 1);
				default: len = $urandom_range(0, LBR_STORE_BYTES);
			endcase
			reg_data = $urandom;
			reg_data[LBR_LEN_W-1:0] = len[LBR_LEN_W-1:0];
			apb_write(ADDR_STREAM_BYTES, reg_data);
			phase_items = $urandom_range(40, 160);
			while (phase_items > 0 && items_sent < random_goal) begin
				pace();
				random_item();
				phase_items--;
			end
		end

		// After the last result the block has nothing left in flight, so a short wait is enough to catch a stray strobe.
		start <= 1'b0;
		while (sb.expected_reads.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (sb.errors == 0 && sb.expected_reads.size() == 0)
			$display("tb_lsb_first_bit_reader_core: clean");
		else
			$display("tb_lsb_first_bit_reader_core: errors");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lbr_pkg.sv
rtl/lbr_ram.sv
rtl/lbr_store.sv
rtl/lsb_first_bit_reader_core.sv
tb/tb_lsb_first_bit_reader_core.sv
